FILE: design/hdgf_pkg.sv
// ----------------------------------------------------------------------------
// hdgf_pkg
// Shared types, constants and the log2 table of the Hubble/deceleration
// grid fit core.
// ----------------------------------------------------------------------------
package hdgf_pkg;

   // sizing
   localparam int MAX_SAMPLES    = 1024;
   localparam int ADDR_W         = $clog2(MAX_SAMPLES);
   localparam int CNT_W          = ADDR_W + 1;
   localparam int LOG_TABLE_BITS = 8;
   localparam int TABLE_SIZE     = 1 << LOG_TABLE_BITS;
   localparam int CHI_WIDTH      = 48;
   localparam logic [CHI_WIDTH-1:0] CHI_MAX = {CHI_WIDTH{1'b1}};

   // sample store entry: redshift, measured modulus, sigma
   localparam int SAMPLE_W = 48;

   // grid
   localparam int GRID_W = 11;
   localparam logic [GRID_W-1:0] GRID_LIMIT = 11'd1024;
   localparam int HACC_W = 27;
   localparam int QACC_W = 28;

   // datapath widths
   localparam int POLY_W   = 51;
   localparam int LOG_IN_W = 48;
   localparam int LOG_P_W  = $clog2(LOG_IN_W);
   localparam int LOG_W    = LOG_P_W + 16;
   localparam int L2D_W    = 24;
   localparam int KMU_W    = 18;
   localparam int PROD_W   = L2D_W + KMU_W;
   localparam int DIFF_W   = 21;
   localparam int AD_W     = 20;
   localparam int SQ_W     = 2 * AD_W;
   localparam int SG_W     = 32;
   localparam int NUM_W    = SQ_W + 20;
   localparam int DCNT_W   = $clog2(NUM_W + 1);

   // constants of the distance and modulus formulas
   localparam logic [63:0] C_SCALED = 64'd76800000;
   localparam int K_MU      = 98642;
   localparam int MU_OFFSET = 25600;
   localparam logic [L2D_W-1:0] L2D_OFF = L2D_W'(41 * 65536);

   // configuration register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] REG_H_START = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_H_STEP  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_H_COUNT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_Q_START = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_Q_STEP  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_Q_COUNT = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_Z_CUT   = 3'd6;

   // operation codes
   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_LOAD  = 2'd1,
      OP_RUN   = 2'd2
   } op_type;

   // channel payloads
   typedef struct packed {
      logic [1:0]  operation;
      logic [15:0] redshift;
      logic [15:0] mu_measured;
      logic [15:0] sigma_err;
   } req_type;

   typedef struct packed {
      logic [15:0]          best_h0;
      logic signed [15:0]   best_q0;
      logic [CHI_WIDTH-1:0] min_chi;
      logic                 fit_found;
      logic [CNT_W-1:0]     samples_used;
   } rsp_type;

   // controller states
   typedef enum logic [4:0] {
      ST_IDLE, ST_INIT, ST_H_TEST, ST_H_LOG, ST_P_START, ST_S_RD, ST_S_CHK,
      ST_S_MUL, ST_S_PCHK, ST_S_LOG, ST_S_MU, ST_S_DIFF, ST_S_SQ, ST_S_DIV,
      ST_S_DIVW, ST_S_ACC, ST_S_NEXT, ST_P_END, ST_P_NEXT, ST_H_NEXT, ST_FINISH
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic clr;
      logic ld;
      logic run_init;
      logic h_log_start;
      logic h_log_save;
      logic pt_init;
      logic rd;
      logic smp_latch;
      logic mul;
      logic plog_start;
      logic l2d_save;
      logic mu_mul;
      logic diff;
      logic sq;
      logic div_start;
      logic acc;
      logic s_next;
      logic pt_update;
      logic q_next;
      logic h_next;
      logic rsp_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic grid_empty;
      logic h_zero;
      logic log_done;
      logic cnt_zero;
      logic z_over;
      logic poly_bad;
      logic sig_zero;
      logic div_done;
      logic s_last;
      logic j_last;
      logic i_last;
      logic rsp_free;
   } stat_type;

   // log2 fraction table, log2(1 + k/TABLE_SIZE) in Q.16
   typedef logic [15:0] log_table_type [TABLE_SIZE];

   function automatic log_table_type build_log_table();
      log_table_type t;
      logic [63:0]   m;
      logic [15:0]   r;
      for (int k = 0; k < TABLE_SIZE; k++) begin
         m = 64'(TABLE_SIZE + k) << (30 - LOG_TABLE_BITS);
         r = '0;
         for (int b = 15; b >= 0; b--) begin
            m = (m * m) >> 30;
            if (m >= (64'd1 << 31)) begin
               m    = m >> 1;
               r[b] = 1'b1;
            end
         end
         t[k] = r;
      end
      return t;
   endfunction

   localparam log_table_type LOG_TABLE = build_log_table();

   // elaboration-time log2 in Q.16
   function automatic logic [LOG_W-1:0] log2_const(input logic [63:0] x);
      int          p;
      logic [63:0] k;
      p = 63;
      while (p > 0 && x[p] == 1'b0) p--;
      if (p >= LOG_TABLE_BITS) k = x >> (p - LOG_TABLE_BITS);
      else k = x << (LOG_TABLE_BITS - p);
      return LOG_W'(p * 65536) + LOG_W'(LOG_TABLE[k[LOG_TABLE_BITS-1:0]]);
   endfunction

   localparam logic [LOG_W-1:0] LC = log2_const(C_SCALED);

endpackage

FILE: design/hdgf_ram.sv
// ----------------------------------------------------------------------------
// hdgf_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module hdgf_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/hdgf_ctrl.sv
// ----------------------------------------------------------------------------
// hdgf_ctrl
// Sequencer of the grid fit: walks H0 rows, q0 points and stored samples and
// steps the datapath through each sample's chi-squared term.
// ----------------------------------------------------------------------------
module hdgf_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic [1:0]         req_operation,
   output logic               req_ready,
   input  hdgf_pkg::stat_type stat,
   output hdgf_pkg::cmd_type  cmd
);
   import hdgf_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign accept = req_valid && (state_ff == ST_IDLE);

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_operation == OP_RUN) state_in = ST_INIT;
         end
         ST_INIT: begin
            // no rows or no columns: empty grid
            state_in = stat.grid_empty ? ST_FINISH : ST_H_TEST;
         end
         ST_H_TEST: begin
            state_in = stat.h_zero ? ST_H_NEXT : ST_H_LOG;
         end
         ST_H_LOG: begin
            if (stat.log_done) state_in = ST_P_START;
         end
         ST_P_START: begin
            state_in = stat.cnt_zero ? ST_P_END : ST_S_RD;
         end
         ST_S_RD:   state_in = ST_S_CHK;
         ST_S_CHK: begin
            state_in = stat.z_over ? ST_S_NEXT : ST_S_MUL;
         end
         ST_S_MUL:  state_in = ST_S_PCHK;
         ST_S_PCHK: begin
            // a non-positive distance voids the whole point
            state_in = stat.poly_bad ? ST_P_NEXT : ST_S_LOG;
         end
         ST_S_LOG: begin
            if (stat.log_done) state_in = ST_S_MU;
         end
         ST_S_MU:   state_in = ST_S_DIFF;
         ST_S_DIFF: state_in = ST_S_SQ;
         ST_S_SQ:   state_in = ST_S_DIV;
         ST_S_DIV: begin
            state_in = stat.sig_zero ? ST_S_ACC : ST_S_DIVW;
         end
         ST_S_DIVW: begin
            if (stat.div_done) state_in = ST_S_ACC;
         end
         ST_S_ACC:  state_in = ST_S_NEXT;
         ST_S_NEXT: begin
            state_in = stat.s_last ? ST_P_END : ST_S_RD;
         end
         ST_P_END:  state_in = ST_P_NEXT;
         ST_P_NEXT: begin
            state_in = stat.j_last ? ST_H_NEXT : ST_P_START;
         end
         ST_H_NEXT: begin
            state_in = stat.i_last ? ST_FINISH : ST_H_TEST;
         end
         ST_FINISH: begin
            if (stat.rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.clr   = accept && (req_operation == OP_CLEAR);
            cmd.ld    = accept && (req_operation == OP_LOAD);
         end
         ST_INIT:    cmd.run_init    = 1'b1;
         ST_H_TEST:  cmd.h_log_start = !stat.h_zero;
         ST_H_LOG:   cmd.h_log_save  = stat.log_done;
         ST_P_START: cmd.pt_init     = 1'b1;
         ST_S_RD:    cmd.rd          = 1'b1;
         ST_S_CHK:   cmd.smp_latch   = 1'b1;
         ST_S_MUL:   cmd.mul         = 1'b1;
         ST_S_PCHK:  cmd.plog_start  = !stat.poly_bad;
         ST_S_LOG:   cmd.l2d_save    = stat.log_done;
         ST_S_MU:    cmd.mu_mul      = 1'b1;
         ST_S_DIFF:  cmd.diff        = 1'b1;
         ST_S_SQ:    cmd.sq          = 1'b1;
         ST_S_DIV:   cmd.div_start   = !stat.sig_zero;
         ST_S_DIVW:  cmd.acc         = 1'b0;
         ST_S_ACC:   cmd.acc         = 1'b1;
         ST_S_NEXT:  cmd.s_next      = 1'b1;
         ST_P_END:   cmd.pt_update   = 1'b1;
         ST_P_NEXT:  cmd.q_next      = 1'b1;
         ST_H_NEXT:  cmd.h_next      = 1'b1;
         ST_FINISH:  cmd.rsp_load    = stat.rsp_free;
         default:    cmd             = '0;
      endcase
   end

endmodule

FILE: design/hdgf_dp.sv
// ----------------------------------------------------------------------------
// hdgf_dp
// Datapath of the grid fit: configuration registers, sample store, grid
// accumulators, log2 normalizer, modulus math, serial divider, best point
// tracking and the result register.
// ----------------------------------------------------------------------------
module hdgf_dp (
   input  logic                             clock,
   input  logic                             reset,
   input  hdgf_pkg::cmd_type                cmd,
   output hdgf_pkg::stat_type               stat,
   input  hdgf_pkg::req_type                req_data,
   input  logic                             csr_valid,
   input  logic [hdgf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [15:0]                      csr_data,
   input  logic                             rsp_ready,
   output logic                             rsp_valid,
   output hdgf_pkg::rsp_type                rsp_data
);
   import hdgf_pkg::*;

   // configuration registers
   logic [15:0]        h_start_ff, h_step_ff, z_cut_ff;
   logic signed [15:0] q_start_ff;
   logic [14:0]        q_step_ff;
   logic [GRID_W-1:0]  h_count_ff, q_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         h_start_ff <= 16'd12800;
         h_step_ff  <= 16'd256;
         h_count_ff <= 11'd41;
         q_start_ff <= -16'sd4096;
         q_step_ff  <= 15'd410;
         q_count_ff <= 11'd21;
         z_cut_ff   <= 16'd4915;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_H_START: h_start_ff <= csr_data;
            REG_H_STEP:  h_step_ff  <= csr_data;
            REG_H_COUNT: h_count_ff <= csr_data[GRID_W-1:0];
            REG_Q_START: q_start_ff <= $signed(csr_data);
            REG_Q_STEP:  q_step_ff  <= csr_data[14:0];
            REG_Q_COUNT: q_count_ff <= csr_data[GRID_W-1:0];
            REG_Z_CUT:   z_cut_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // sample count and store
   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    s_ff;
   logic                wr_en;
   logic [SAMPLE_W-1:0] rd_data;
   logic [15:0]         rd_z, rd_mu, rd_sig;

   assign wr_en = cmd.ld && (count_ff < CNT_W'(MAX_SAMPLES));

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.clr) begin
         count_ff <= '0;
      end else if (wr_en) begin
         count_ff <= count_ff + 1'b1;
      end
   end

   hdgf_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (MAX_SAMPLES)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data ({req_data.redshift, req_data.mu_measured, req_data.sigma_err}),
      .rd_en   (cmd.rd),
      .rd_addr (s_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   assign rd_z   = rd_data[47:32];
   assign rd_mu  = rd_data[31:16];
   assign rd_sig = rd_data[15:0];

   // grid walk
   logic [GRID_W-1:0]        i_ff, j_ff, hc_eff, qc_eff;
   logic [HACC_W-1:0]        h_acc_ff;
   logic signed [QACC_W-1:0] q_acc_ff;
   logic [15:0]              h_cur;
   logic signed [15:0]       q_cur;
   logic [LOG_W-1:0]         lh_ff;
   logic [LOG_W-1:0]         log_res;

   assign hc_eff = (h_count_ff > GRID_LIMIT) ? GRID_LIMIT : h_count_ff;
   assign qc_eff = (q_count_ff > GRID_LIMIT) ? GRID_LIMIT : q_count_ff;
   assign h_cur  = (h_acc_ff > HACC_W'(16'hFFFF)) ? 16'hFFFF : h_acc_ff[15:0];
   assign q_cur  = (q_acc_ff > $signed(QACC_W'(32767))) ? 16'sh7FFF
                                                        : q_acc_ff[15:0];

   always_ff @(posedge clock) begin
      if (cmd.run_init) begin
         i_ff     <= '0;
         h_acc_ff <= HACC_W'(h_start_ff);
      end else if (cmd.h_next) begin
         i_ff     <= i_ff + 1'b1;
         h_acc_ff <= h_acc_ff + HACC_W'(h_step_ff);
      end
      if (cmd.h_log_save) begin
         j_ff     <= '0;
         q_acc_ff <= QACC_W'(q_start_ff);
         lh_ff    <= log_res;
      end else if (cmd.q_next) begin
         j_ff     <= j_ff + 1'b1;
         q_acc_ff <= q_acc_ff + $signed(QACC_W'(q_step_ff));
      end
   end

   // sample walk and operand capture
   logic [15:0]              z_ff, mu_ff, sig_ff;
   logic [31:0]              z2_ff;
   logic signed [POLY_W-1:0] poly_ff;
   logic signed [17:0]       wq;

   assign wq = 18'sd4096 - $signed({{2{q_cur[15]}}, q_cur});

   always_ff @(posedge clock) begin
      if (cmd.pt_init) begin
         s_ff <= '0;
      end else if (cmd.s_next) begin
         s_ff <= s_ff + 1'b1;
      end
      if (cmd.smp_latch) begin
         z_ff   <= rd_z;
         mu_ff  <= rd_mu;
         sig_ff <= rd_sig;
         z2_ff  <= rd_z * rd_z;
      end
      // P = z*2^27 + (4096 - q0)*z^2
      if (cmd.mul) begin
         poly_ff <= $signed(POLY_W'({z_ff, 27'd0})) + (wq * $signed({1'b0, z2_ff}));
      end
   end

   // log2 normalizer: byte shifts then bit shifts to the leading one
   logic                log_busy_ff;
   logic [LOG_IN_W-1:0] log_n_ff;
   logic [LOG_P_W-1:0]  log_p_ff;
   logic                log_start, log_done;
   logic [LOG_IN_W-1:0] log_src;

   assign log_start = cmd.h_log_start || cmd.plog_start;
   assign log_src   = cmd.h_log_start ? LOG_IN_W'(h_cur) : poly_ff[LOG_IN_W-1:0];
   assign log_done  = log_busy_ff && (log_n_ff[LOG_IN_W-1] || log_p_ff == '0);
   assign log_res   = {log_p_ff, LOG_TABLE[log_n_ff[LOG_IN_W-2 -: LOG_TABLE_BITS]]};

   always_ff @(posedge clock) begin
      if (reset) begin
         log_busy_ff <= 1'b0;
      end else if (log_start) begin
         log_busy_ff <= 1'b1;
      end else if (log_done) begin
         log_busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (log_start) begin
         log_n_ff <= log_src;
         log_p_ff <= LOG_P_W'(LOG_IN_W - 1);
      end else if (log_busy_ff && !log_done) begin
         if (log_n_ff[LOG_IN_W-1 -: 8] == 8'd0 && log_p_ff >= LOG_P_W'(8)) begin
            log_n_ff <= log_n_ff << 8;
            log_p_ff <= log_p_ff - LOG_P_W'(8);
         end else begin
            log_n_ff <= log_n_ff << 1;
            log_p_ff <= log_p_ff - 1'b1;
         end
      end
   end

   // modulus and residual
   logic signed [L2D_W-1:0]  l2d_ff;
   logic signed [PROD_W-1:0] prod_ff, rnd;
   logic signed [DIFF_W-1:0] mu_theo, diff;
   logic [AD_W-1:0]          ad_ff;
   logic [SQ_W-1:0]          sq_ff;
   logic [SG_W-1:0]          sg_ff;

   assign rnd     = prod_ff + $signed(PROD_W'(1 << 21));
   assign mu_theo = $signed({rnd[PROD_W-1], rnd[PROD_W-1:22]})
                    + $signed(DIFF_W'(MU_OFFSET));
   assign diff    = $signed(DIFF_W'(mu_ff)) - mu_theo;

   always_ff @(posedge clock) begin
      // log2 d = log2 c + log2 P - log2 H0 - 41
      if (cmd.l2d_save) begin
         l2d_ff <= $signed(L2D_W'(LC) + L2D_W'(log_res) - L2D_W'(lh_ff) - L2D_OFF);
      end
      if (cmd.mu_mul) begin
         prod_ff <= l2d_ff * $signed(KMU_W'(K_MU));
      end
      if (cmd.diff) begin
         ad_ff <= diff[DIFF_W-1] ? AD_W'(-diff) : AD_W'(diff);
      end
      if (cmd.sq) begin
         sq_ff <= ad_ff * ad_ff;
         sg_ff <= sig_ff * sig_ff;
      end
   end

   // restoring divider, one quotient bit per cycle
   logic [SG_W-1:0]   rem_ff;
   logic [NUM_W-1:0]  quo_ff;
   logic [DCNT_W-1:0] dcnt_ff;
   logic [SG_W:0]     trial;
   logic              fits;

   assign trial = {rem_ff, quo_ff[NUM_W-1]};
   assign fits  = trial >= {1'b0, sg_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         dcnt_ff <= '0;
      end else if (cmd.div_start) begin
         dcnt_ff <= DCNT_W'(NUM_W);
      end else if (dcnt_ff != '0) begin
         dcnt_ff <= dcnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         rem_ff <= '0;
         quo_ff <= {sq_ff, 20'd0};
      end else if (dcnt_ff != '0) begin
         rem_ff <= fits ? SG_W'(trial - {1'b0, sg_ff}) : trial[SG_W-1:0];
         quo_ff <= {quo_ff[NUM_W-2:0], fits};
      end
   end

   // saturating chi-squared sum
   logic [CHI_WIDTH-1:0] term, sum_ff;
   logic [CHI_WIDTH:0]   sum_add;

   assign term = (sig_ff == 16'd0 || quo_ff[NUM_W-1:CHI_WIDTH] != '0) ? CHI_MAX
                                                                    : quo_ff[CHI_WIDTH-1:0];
   assign sum_add = {1'b0, sum_ff} + {1'b0, term};

   always_ff @(posedge clock) begin
      if (cmd.pt_init) begin
         sum_ff <= '0;
      end else if (cmd.acc) begin
         sum_ff <= sum_add[CHI_WIDTH] ? CHI_MAX : sum_add[CHI_WIDTH-1:0];
      end
   end

   // best point, first strict minimum wins
   logic                 found_ff;
   logic [CHI_WIDTH-1:0] best_ff;
   logic [15:0]          best_h_ff;
   logic signed [15:0]   best_q_ff;

   always_ff @(posedge clock) begin
      if (cmd.run_init) begin
         found_ff  <= 1'b0;
         best_ff   <= CHI_MAX;
         best_h_ff <= '0;
         best_q_ff <= '0;
      end else if (cmd.pt_update && (!found_ff || sum_ff < best_ff)) begin
         found_ff  <= 1'b1;
         best_ff   <= sum_ff;
         best_h_ff <= h_cur;
         best_q_ff <= q_cur;
      end
   end

   // result register
   logic    rsp_valid_ff;
   rsp_type rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_ff.best_h0      <= best_h_ff;
         rsp_ff.best_q0      <= best_q_ff;
         rsp_ff.min_chi      <= best_ff;
         rsp_ff.fit_found    <= found_ff;
         rsp_ff.samples_used <= count_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // status to the controller
   always_comb begin
      stat.grid_empty = (hc_eff == '0) || (qc_eff == '0);
      stat.h_zero     = (h_cur == 16'd0);
      stat.log_done   = log_done;
      stat.cnt_zero   = (count_ff == '0);
      stat.z_over     = (rd_z > z_cut_ff);
      stat.poly_bad   = poly_ff[POLY_W-1] || (poly_ff == '0);
      stat.sig_zero   = (sig_ff == 16'd0);
      stat.div_done   = (dcnt_ff == '0);
      stat.s_last     = (s_ff + 1'b1 == count_ff);
      stat.j_last     = (j_ff + 1'b1 == qc_eff);
      stat.i_last     = (i_ff + 1'b1 == hc_eff);
      stat.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

endmodule

FILE: design/hubble_deceleration_grid_fit_core.sv
// ----------------------------------------------------------------------------
// hubble_deceleration_grid_fit_core
// Chi-squared grid search of H0 and q0 over stored redshift/modulus samples.
// ----------------------------------------------------------------------------
// Usage:
//  req channel: one beat carries an operation and a sample. Clear empties the
//  sample store, load appends a sample (ignored once 1024 are held), run
//  starts a fit. Clear and load give no rsp beat.
//  rsp channel: one beat per run with the best grid point, its chi-squared
//  sum, a found flag and the sample count.
//  csr channel: seven grid/cut registers, always ready, one write per cycle;
//  write only while no run is in progress.
//  In a run, a sample above the redshift cut is skipped; a used sample goes
//  through the log2 normalizer and the restoring divider, one quotient bit
//  per cycle. req_ready is low during a run.
//  Reset (synchronous) empties the store, loads register defaults and drops
//  rsp_valid. A stalled rsp beat stays in the output register; clears and
//  loads are still taken meanwhile, and a following run waits at its end
//  until the register is free.
// ----------------------------------------------------------------------------
module hubble_deceleration_grid_fit_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  hdgf_pkg::req_type              req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output hdgf_pkg::rsp_type              rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [hdgf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]                    csr_data
);
   import hdgf_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   assign csr_ready = 1'b1;

   // sequencer
   hdgf_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_data.operation),
      .req_ready     (req_ready),
      .stat          (stat),
      .cmd           (cmd)
   );

   // datapath
   hdgf_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   // a run beat closes the input side for the run
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.operation == OP_RUN) |=> !req_ready)
      else $error("input still ready after run start");

   // no valid point reports the empty result
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.fit_found) |->
      (rsp_data.min_chi == CHI_MAX && rsp_data.best_h0 == 16'd0))
      else $error("empty fit result malformed");

   // a zero H0 row is void, so a found point never has zero H0
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.fit_found) |-> rsp_data.best_h0 != 16'd0)
      else $error("best point with zero H0");

   // sample count never passes the store depth
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.samples_used <= CNT_W'(MAX_SAMPLES))
      else $error("sample count beyond store depth");
`endif

endmodule
